/* hdl/pfib_pkg.sv */
// ----------------------------------------------------------------------------
// pfib_pkg
// Types and constants shared by the paged flash image buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package pfib_pkg;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic REG_PAGE_WORDS = 1'b0;
	localparam logic REG_PAGE_CAP   = 1'b1;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;
	localparam logic [8:0] PAGE_WORDS_RST = 9'd64;
	localparam logic [12:0] PAGE_CAP_RST = 13'd0;
	localparam int QUO_W = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [16:0] byte_address;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic        address_error;
		logic [7:0]  read_byte;
		logic [2:0]  word_marks;
		logic [2:0]  page_marks;
		logic [2:0]  image_marks;
	} rsp_t;

	typedef struct packed {
		logic latch_in;
		logic div_init;
		logic div_step;
		logic check;
		logic mem_read;
		logic mem_write;
		logic sweep_start;
		logic sweep_run;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       div_done;
		logic       sweep_last;
	} sts_t;

endpackage

`default_nettype wire

/* hdl/paged_flash_image_buffer.sv */
// ----------------------------------------------------------------------------
// paged_flash_image_buffer
// Byte-addressed flash image in 16-bit words and pages, with used, changed
// and known marks per word, per page and for the whole image.
// ----------------------------------------------------------------------------
//  channel | signals                                  | payload
//  req     | req_valid / req_ready                    | pfib_pkg::req_t
//  rsp     | rsp_valid / rsp_ready                    | pfib_pkg::rsp_t
//  cfg     | psel penable pwrite paddr pwdata prdata  | page size, page cap
//
// Read and write requests pass, from one accept to the next, through the
// accept, dispatch, 16 steps of the bit-serial page divider and a finishing
// step, check, memory read and update; the response is registered at the
// update. End-session and clear sweep the mark memories, one entry a cycle;
// clear also erases the bytes to FF. After reset a clearing pass over
// max(WORD_CAPACITY, MAX_PAGES) entries runs with req_ready low. A waiting
// response holds only the final update step, or the hold step of a sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_flash_image_buffer #(
	parameter int WORD_CAPACITY = 65536,
	parameter int MAX_PAGES     = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire pfib_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output pfib_pkg::rsp_t      rsp,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [8:0]  page_words_q;
	logic [12:0] page_cap_q;
	logic        wr;
	pfib_pkg::cmd_t cmd;
	pfib_pkg::sts_t sts;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_words_q <= pfib_pkg::PAGE_WORDS_RST;
			page_cap_q   <= pfib_pkg::PAGE_CAP_RST;
		end else if (wr) begin
			unique case (paddr[2])
				pfib_pkg::REG_PAGE_WORDS: page_words_q <= pwdata[8:0];
				pfib_pkg::REG_PAGE_CAP:   page_cap_q   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pfib_pkg::REG_PAGE_WORDS: prdata = {23'd0, page_words_q};
			pfib_pkg::REG_PAGE_CAP:   prdata = {19'd0, page_cap_q};
			default: prdata = '0;
		endcase
	end

	pfib_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pfib_datapath #(
		.WORD_CAPACITY (WORD_CAPACITY),
		.MAX_PAGES     (MAX_PAGES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.page_words (page_words_q),
		.page_cap   (page_cap_q),
		.cmd        (cmd),
		.sts        (sts),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

/* hdl/pfib_ctrl.sv */
// ----------------------------------------------------------------------------
// pfib_ctrl
// Sequencer: reset clearing pass, address division, memory access, sweeps, response.
// ----------------------------------------------------------------------------
`default_nettype none

module pfib_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	input  wire pfib_pkg::sts_t sts,
	output pfib_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DISP  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_UPD   = 3'd6;
	localparam logic [2:0] ST_HOLD  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       sweep_q, sweep_d;
	logic       rsp_valid_q;
	logic       can_load;

	assign can_load  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		sweep_d = sweep_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_run = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.kind) inside
					pfib_pkg::KIND_END, pfib_pkg::KIND_CLEAR: begin
						cmd.sweep_start = 1'b1;
						sweep_d = 1'b1;
						state_d = ST_DIV;
					end
					default: begin
						cmd.div_init = 1'b1;
						state_d = ST_DIV;
					end
				endcase
			end
			ST_DIV: begin
				if (sweep_q) begin
					cmd.sweep_run = 1'b1;
					if (sts.sweep_last) begin
						sweep_d = 1'b0;
						state_d = ST_HOLD;
					end
				end else if (sts.div_done) begin
					state_d = ST_CHECK;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.mem_read = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (can_load) begin
					cmd.mem_write   = 1'b1;
					cmd.result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (can_load) begin
					cmd.result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			if (cmd.result_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* hdl/pfib_datapath.sv */
// ----------------------------------------------------------------------------
// pfib_datapath
// Byte and mark memories, page divider, limit check, sweep counter, response.
// ----------------------------------------------------------------------------
`default_nettype none

module pfib_datapath #(
	parameter int WORD_CAPACITY = 65536,
	parameter int MAX_PAGES     = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pfib_pkg::req_t req,
	input  wire logic [8:0]     page_words,
	input  wire logic [12:0]    page_cap,
	input  wire pfib_pkg::cmd_t cmd,
	output pfib_pkg::sts_t      sts,
	output pfib_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(WORD_CAPACITY);
	localparam int PW = $clog2(MAX_PAGES);
	localparam int SWEEP_N = (WORD_CAPACITY > MAX_PAGES) ? WORD_CAPACITY : MAX_PAGES;
	localparam int CW = $clog2(SWEEP_N);
	localparam int QW = pfib_pkg::QUO_W;

	logic [AW-1:0] bytes_idx;
	logic [7:0]  low_mem  [WORD_CAPACITY];
	logic [7:0]  high_mem [WORD_CAPACITY];
	logic        wk_mem   [WORD_CAPACITY];
	logic [1:0]  wuc_mem  [WORD_CAPACITY];
	logic        pk_mem   [MAX_PAGES];
	logic [1:0]  puc_mem  [MAX_PAGES];

	pfib_pkg::req_t req_q;
	logic [9:0]  rem_q;
	logic [QW-1:0] quo_q;
	logic [4:0]  cnt_q;
	logic [21:0] prod_q;
	logic        bad_q;
	logic [CW-1:0] swp_q;
	logic        clr_q;
	logic [2:0]  image_q;
	logic [7:0]  lo_rd_q, hi_rd_q;
	logic        wk_rd_q, pk_rd_q;
	logic [1:0]  wuc_rd_q, puc_rd_q;
	pfib_pkg::rsp_t rsp_q;

	logic [31:0] widx32, pg32, swp32;
	logic [9:0]  trial;
	logic        fits;
	logic [7:0]  cur_byte;
	logic        diff, is_wr;
	logic [AW-1:0] w_idx, sw_widx;
	logic [PW-1:0] p_idx, sw_pidx;
	logic        sw_w_ok, sw_p_ok;
	logic [1:0]  wuc_new, puc_new;

	assign widx32 = 32'(req_q.byte_address[16:1]);
	assign pg32   = 32'(quo_q);
	assign swp32  = 32'(swp_q);
	assign w_idx  = widx32[AW-1:0];
	assign p_idx  = pg32[PW-1:0];
	assign sw_widx = swp_q[AW-1:0];
	assign sw_pidx = swp_q[PW-1:0];
	assign sw_w_ok = (swp32 < 32'(WORD_CAPACITY));
	assign sw_p_ok = (swp32 < 32'(MAX_PAGES));
	assign bytes_idx = w_idx;

	assign trial = {rem_q[8:0], quo_q[QW-1]};
	assign fits  = (trial >= {1'b0, page_words});

	assign cur_byte = req_q.byte_address[0] ? hi_rd_q : lo_rd_q;
	assign diff  = !wk_rd_q || (cur_byte != req_q.write_byte);
	assign is_wr = (req_q.kind == pfib_pkg::KIND_WRITE);
	assign wuc_new = wuc_rd_q | {diff, 1'b1};
	assign puc_new = puc_rd_q | {diff, 1'b1};

	assign sts.kind       = req_q.kind;
	assign sts.div_done   = (cnt_q == 5'(QW));
	assign sts.sweep_last = (swp_q == CW'(SWEEP_N - 1));
	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) req_q <= req;
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= req_q.byte_address[16:1];
			cnt_q  <= '0;
			prod_q <= page_cap * page_words;
		end else if (cmd.div_step) begin
			rem_q <= fits ? (trial - {1'b0, page_words}) : trial;
			quo_q <= {quo_q[QW-2:0], fits};
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.check) begin
			bad_q <= (page_words == 9'd0)
				|| ((page_cap != 13'd0) &&
				    ({15'd0, req_q.byte_address} >= {9'd0, prod_q, 1'b0}))
				|| (widx32 >= 32'(WORD_CAPACITY))
				|| (pg32 >= 32'(MAX_PAGES));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			lo_rd_q  <= low_mem[bytes_idx];
			hi_rd_q  <= high_mem[bytes_idx];
			wk_rd_q  <= wk_mem[w_idx];
			wuc_rd_q <= wuc_mem[w_idx];
			pk_rd_q  <= pk_mem[p_idx];
			puc_rd_q <= puc_mem[p_idx];
		end
	end

	// byte stores
	always_ff @(posedge clk) begin
		if (cmd.sweep_run && clr_q && sw_w_ok) begin
			low_mem[sw_widx]  <= pfib_pkg::ERASED_BYTE;
			high_mem[sw_widx] <= pfib_pkg::ERASED_BYTE;
		end else if (cmd.mem_write && is_wr && !bad_q && diff) begin
			if (req_q.byte_address[0]) high_mem[w_idx] <= req_q.write_byte;
			else low_mem[w_idx] <= req_q.write_byte;
		end
	end

	// word and page marks; known kept apart so end-session needs no read
	always_ff @(posedge clk) begin
		if (cmd.sweep_run) begin
			if (sw_w_ok) begin
				wuc_mem[sw_widx] <= 2'b00;
				if (clr_q) wk_mem[sw_widx] <= 1'b0;
			end
			if (sw_p_ok) begin
				puc_mem[sw_pidx] <= 2'b00;
				if (clr_q) pk_mem[sw_pidx] <= 1'b0;
			end
		end else if (cmd.mem_write && is_wr && !bad_q) begin
			wk_mem[w_idx]  <= 1'b1;
			wuc_mem[w_idx] <= wuc_new;
			pk_mem[p_idx]  <= 1'b1;
			puc_mem[p_idx] <= puc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_q   <= '0;
			clr_q   <= 1'b1;
			image_q <= 3'b000;
		end else begin
			if (cmd.sweep_start) begin
				swp_q <= '0;
				clr_q <= (req_q.kind == pfib_pkg::KIND_CLEAR);
				image_q <= (req_q.kind == pfib_pkg::KIND_CLEAR) ? 3'b000
					: (image_q & 3'b100);
			end else if (cmd.sweep_run) begin
				swp_q <= sts.sweep_last ? '0 : swp_q + CW'(1);
			end else if (cmd.mem_write && is_wr && !bad_q) begin
				image_q <= image_q | {1'b1, diff, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			rsp_q.address_error <= 1'b0;
			rsp_q.read_byte     <= pfib_pkg::ERASED_BYTE;
			rsp_q.word_marks    <= 3'b000;
			rsp_q.page_marks    <= 3'b000;
			rsp_q.image_marks   <= image_q;
			if (cmd.mem_write) begin
				if (bad_q) begin
					rsp_q.address_error <= 1'b1;
				end else if (is_wr) begin
					rsp_q.read_byte   <= req_q.write_byte;
					rsp_q.word_marks  <= {1'b1, wuc_new};
					rsp_q.page_marks  <= {1'b1, puc_new};
					rsp_q.image_marks <= image_q | {1'b1, diff, 1'b1};
				end else begin
					rsp_q.read_byte  <= cur_byte;
					rsp_q.word_marks <= {wk_rd_q, wuc_rd_q};
					rsp_q.page_marks <= {pk_rd_q, puc_rd_q};
				end
			end
		end
	end

endmodule

`default_nettype wire
